// File: rtl/ljv_pkg.sv
`default_nettype none
package ljv_pkg;

   localparam int MaxParticles = 256;
   localparam int IdxW         = $clog2(MaxParticles);
   localparam int CntW         = IdxW + 1;
   localparam int FracBits     = 24;
   localparam int AccW         = 40;
   localparam int DivNumW      = 2 * FracBits + 1;
   localparam int DivDenW      = 40;
   localparam int DivCntW      = $clog2(DivNumW + 1);

   localparam logic [1:0] FuncLoad = 2'd0;
   localparam logic [1:0] FuncStep = 2'd1;
   localparam logic [1:0] FuncRead = 2'd2;

   localparam logic [2:0] CsrCount  = 3'd0;
   localparam logic [2:0] CsrBox    = 3'd1;
   localparam logic [2:0] CsrRecip  = 3'd2;
   localparam logic [2:0] CsrCutoff = 3'd3;
   localparam logic [2:0] CsrStepSq = 3'd4;
   localparam logic [2:0] CsrHalfInv = 3'd5;

   typedef logic signed [31:0]     word_type;
   typedef logic signed [AccW-1:0] acc_type;

   function automatic word_type sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -66'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic ovf32(input logic signed [65:0] v);
      return (v > 66'sd2147483647) || (v < -66'sd2147483648);
   endfunction

   function automatic logic signed [65:0] fround(input logic signed [63:0] p);
      logic signed [65:0] e;
      e = 66'(p) + (66'sd1 <<< (FracBits - 1));
      return e >>> FracBits;
   endfunction

   function automatic acc_type sat40(input logic signed [AccW:0] v);
      if (v[AccW] != v[AccW-1]) begin
         return v[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
      end
      return v[AccW-1:0];
   endfunction

   function automatic logic ovf40(input logic signed [AccW:0] v);
      return v[AccW] != v[AccW-1];
   endfunction

endpackage
`default_nettype wire

// File: rtl/ljv_div.sv
`default_nettype none
module ljv_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [ljv_pkg::DivNumW-1:0] num,
   input  wire logic [ljv_pkg::DivDenW-1:0] den,
   output logic                             done,
   output logic [ljv_pkg::DivNumW-1:0]      quo
);
   import ljv_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DivCntW-1:0]  cnt_ff, cnt_in;
   logic [DivNumW-1:0]  num_ff, num_in;
   logic [DivNumW-1:0]  quo_ff, quo_in;
   logic [DivDenW-1:0]  den_ff, den_in;
   logic [DivDenW-1:0]  rem_ff, rem_in;
   logic [DivDenW:0]    shifted;

   assign shifted = {rem_ff, num_ff[DivNumW-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DivCntW'(DivNumW);
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[DivNumW-2:0], 1'b0};
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = DivDenW'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[DivNumW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DivDenW-1:0];
            quo_in = {quo_ff[DivNumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DivCntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

// File: rtl/lj_force_verlet_step.sv
// Lennard-Jones position Verlet step engine.
// req_ channel: one transaction per item. req_func selects load (writes the
// current and previous position of req_particle_index), step (advances all
// particles in use by one time step) or read (returns position and velocity); any other code is only answered.
// rsp_ channel: exactly one transaction per request, in order; position and
// velocity fields are zero except for a read. rsp_saturated is the sticky
// overflow flag, cleared only by reset.
// csr_ channel: register writes, always ready; write only while idle.
// A load's response is registered in the cycle after acceptance; a read passes through StRdWait first.
// A step with N particles runs a force pass over its N*(N-1) ordered pairs
// (three wraps, a bit-serial reciprocal and a chain of products through the
// single shared 32x32 multiplier per pair inside the cutoff, only the wraps
// and squares for a pair outside it), then an update pass over every particle.
// Reset clears the configuration to defaults, zeros all velocities through
// per-entry valid bits and clears the flag; position memories need a load
// before use. A stalled rsp_ holds its transaction and blocks new requests.
`default_nettype none
module lj_force_verlet_step (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_func,
   input  wire logic [7:0]          req_particle_index,
   input  wire logic signed [31:0]  req_load_x,
   input  wire logic signed [31:0]  req_load_y,
   input  wire logic signed [31:0]  req_load_z,
   input  wire logic signed [31:0]  req_load_prev_x,
   input  wire logic signed [31:0]  req_load_prev_y,
   input  wire logic signed [31:0]  req_load_prev_z,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [31:0]       rsp_pos_x,
   output logic signed [31:0]       rsp_pos_y,
   output logic signed [31:0]       rsp_pos_z,
   output logic signed [31:0]       rsp_vel_x,
   output logic signed [31:0]       rsp_vel_y,
   output logic signed [31:0]       rsp_vel_z,
   output logic                     rsp_saturated,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [2:0]          csr_index,
   input  wire logic [31:0]         csr_wdata
);
   import ljv_pkg::*;

   localparam logic [5:0] StIdle   = 6'd0;
   localparam logic [5:0] StRdWait = 6'd1;
   localparam logic [5:0] StCut    = 6'd2;
   localparam logic [5:0] StCut1   = 6'd3;
   localparam logic [5:0] StFRdI   = 6'd4;
   localparam logic [5:0] StFLatI  = 6'd5;
   localparam logic [5:0] StFJChk  = 6'd6;
   localparam logic [5:0] StFLatJ  = 6'd7;
   localparam logic [5:0] StPDiff  = 6'd8;
   localparam logic [5:0] StPSq    = 6'd9;
   localparam logic [5:0] StPAcc   = 6'd10;
   localparam logic [5:0] StPCmp   = 6'd11;
   localparam logic [5:0] StPDiv   = 6'd12;
   localparam logic [5:0] StPS2    = 6'd13;
   localparam logic [5:0] StPS2R   = 6'd14;
   localparam logic [5:0] StPS3R   = 6'd15;
   localparam logic [5:0] StPS4R   = 6'd16;
   localparam logic [5:0] StPFacR  = 6'd17;
   localparam logic [5:0] StPDf    = 6'd18;
   localparam logic [5:0] StPDfR   = 6'd19;
   localparam logic [5:0] StPNextJ = 6'd20;
   localparam logic [5:0] StFWrF   = 6'd21;
   localparam logic [5:0] StARd    = 6'd22;
   localparam logic [5:0] StALat   = 6'd23;
   localparam logic [5:0] StAFd    = 6'd24;
   localparam logic [5:0] StAFdR   = 6'd25;
   localparam logic [5:0] StADisp  = 6'd26;
   localparam logic [5:0] StAVel   = 6'd27;
   localparam logic [5:0] StAVelR  = 6'd28;
   localparam logic [5:0] StAWr    = 6'd29;
   localparam logic [5:0] StDone   = 6'd30;
   localparam logic [5:0] StWrapA  = 6'd31;
   localparam logic [5:0] StWrapB  = 6'd32;
   localparam logic [5:0] StWrapC  = 6'd33;

   logic [5:0] state_ff, state_in, ret_ff, ret_in;

   logic [8:0]  count_ff, count_in;
   logic [30:0] box_ff, box_in, recip_ff, recip_in, cutoff_ff, cutoff_in;
   logic [30:0] stepsq_ff, stepsq_in, halfinv_ff, halfinv_in;
   logic        flag_ff, flag_in, sat_set;

   logic        rsp_valid_ff, rsp_valid_in, rsp_sat_ff, rsp_sat_in;
   word_type    rsp_pos_ff [3];
   word_type    rsp_pos_in [3];
   word_type    rsp_vel_ff [3];
   word_type    rsp_vel_in [3];

   logic [CntW-1:0] i_ff, i_in, j_ff, j_in, n_ff, n_in;
   logic [1:0]      k_ff, k_in;

   word_type ci_ff [3];
   word_type ci_in [3];
   word_type cj_ff [3];
   word_type cj_in [3];
   word_type pi_ff [3];
   word_type pi_in [3];
   acc_type  fi_ff [3];
   acc_type  fi_in [3];
   word_type d_ff [3];
   word_type d_in [3];
   word_type nxt_ff [3];
   word_type nxt_in [3];
   word_type vel_ff [3];
   word_type vel_in [3];
   acc_type  acc_ff [3];
   acc_type  acc_in [3];

   logic [63:0] r2_ff, r2_in, cut2_ff, cut2_in;
   word_type    s_ff, s_in, s2_ff, s2_in, s3_ff, s3_in, factor_ff, factor_in;
   word_type    v_ff, v_in, wres_ff, wres_in;
   logic signed [39:0] wrap_in_ff, wrap_in_in;

   logic signed [63:0] prod_ff;
   word_type           mul_a, mul_b;

   logic signed [65:0] fr_val, wrap_diff, t_val;
   word_type           fr_sat, t_sat;
   logic               fr_ovf;
   logic signed [64:0] nr;
   logic [64:0]        r2_rnd;
   logic [DivDenW-1:0] r2q;
   logic signed [AccW:0] acc_sum;

   logic [95:0]  cur_mem [MaxParticles];
   logic [95:0]  prev_mem [MaxParticles];
   logic [95:0]  vel_mem [MaxParticles];
   logic [119:0] force_mem [MaxParticles];
   logic [MaxParticles-1:0] vel_vld_ff, vel_vld_in;

   logic [95:0]  cur_rd_ff, prev_rd_ff, vel_rd_ff;
   logic [119:0] force_rd_ff;
   logic         vel_vld_rd_ff;
   logic [IdxW-1:0] cur_raddr, waddr;
   logic         cur_we, prev_we, vel_we, force_we;
   logic [95:0]  cur_wdata, prev_wdata, vel_wdata;
   logic [119:0] force_wdata;

   logic                 div_start, div_done;
   logic [DivNumW-1:0]   div_num, div_quo;

   logic req_fire;

   ljv_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (r2q),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_ready = (state_ff == StIdle) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign fr_val    = fround(prod_ff);
   assign fr_sat    = sat32(fr_val);
   assign fr_ovf    = ovf32(fr_val);
   assign nr        = 65'(prod_ff) + (65'sd1 <<< (2 * FracBits - 1));
   assign wrap_diff = 66'(v_ff) - 66'(prod_ff);
   assign t_val     = (66'(s3_ff) <<< 5) + (66'(s3_ff) <<< 4) - (66'sd24 <<< FracBits);
   assign t_sat     = sat32(t_val);
   assign r2_rnd    = {1'b0, r2_ff} + (65'd1 << (FracBits - 1));
   assign r2q       = r2_rnd[FracBits +: DivDenW];
   assign div_num   = (DivNumW'(1) << (2 * FracBits)) + DivNumW'(r2q >> 1);
   assign acc_sum   = (AccW+1)'(acc_ff[k_ff]) + (AccW+1)'(fr_sat);

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      count_in   = count_ff;
      box_in     = box_ff;
      recip_in   = recip_ff;
      cutoff_in  = cutoff_ff;
      stepsq_in  = stepsq_ff;
      halfinv_in = halfinv_ff;
      sat_set    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sat_in = rsp_sat_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_vel_in = rsp_vel_ff;
      i_in = i_ff;
      j_in = j_ff;
      n_in = n_ff;
      k_in = k_ff;
      ci_in = ci_ff;
      cj_in = cj_ff;
      pi_in = pi_ff;
      fi_in = fi_ff;
      d_in = d_ff;
      nxt_in = nxt_ff;
      vel_in = vel_ff;
      acc_in = acc_ff;
      r2_in = r2_ff;
      cut2_in = cut2_ff;
      s_in = s_ff;
      s2_in = s2_ff;
      s3_in = s3_ff;
      factor_in = factor_ff;
      v_in = v_ff;
      wres_in = wres_ff;
      wrap_in_in = wrap_in_ff;
      mul_a = '0;
      mul_b = '0;
      vel_vld_in = vel_vld_ff;
      cur_raddr = i_ff[IdxW-1:0];
      waddr = i_ff[IdxW-1:0];
      cur_we = 1'b0;
      prev_we = 1'b0;
      vel_we = 1'b0;
      force_we = 1'b0;
      cur_wdata = '0;
      prev_wdata = '0;
      vel_wdata = '0;
      force_wdata = '0;
      div_start = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            CsrCount:   count_in   = csr_wdata[8:0];
            CsrBox:     box_in     = csr_wdata[30:0];
            CsrRecip:   recip_in   = csr_wdata[30:0];
            CsrCutoff:  cutoff_in  = csr_wdata[30:0];
            CsrStepSq:  stepsq_in  = csr_wdata[30:0];
            CsrHalfInv: halfinv_in = csr_wdata[30:0];
            default: ;
         endcase
      end

      case (state_ff)
         StIdle: begin
            cur_raddr = req_particle_index;
            if (req_fire) begin
               for (int e = 0; e < 3; e++) begin
                  rsp_pos_in[e] = '0;
                  rsp_vel_in[e] = '0;
               end
               rsp_sat_in = flag_ff;
               case (req_func)
                  FuncLoad: begin
                     waddr = req_particle_index;
                     cur_we = 1'b1;
                     prev_we = 1'b1;
                     cur_wdata = {req_load_z, req_load_y, req_load_x};
                     prev_wdata = {req_load_prev_z, req_load_prev_y, req_load_prev_x};
                     rsp_valid_in = 1'b1;
                  end
                  FuncStep: state_in = StCut;
                  FuncRead: state_in = StRdWait;
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         StRdWait: begin
            for (int e = 0; e < 3; e++) begin
               rsp_pos_in[e] = cur_rd_ff[32*e +: 32];
               rsp_vel_in[e] = vel_vld_rd_ff ? vel_rd_ff[32*e +: 32] : '0;
            end
            rsp_valid_in = 1'b1;
            state_in = StIdle;
         end
         StCut: begin
            mul_a = {1'b0, cutoff_ff};
            mul_b = {1'b0, cutoff_ff};
            state_in = StCut1;
         end
         StCut1: begin
            cut2_in = 64'(prod_ff);
            n_in = (count_ff > 9'(MaxParticles)) ? CntW'(MaxParticles) : CntW'(count_ff);
            i_in = '0;
            state_in = (n_in == '0) ? StDone : StFRdI;
         end
         StFRdI: state_in = StFLatI;
         StFLatI: begin
            for (int e = 0; e < 3; e++) begin
               ci_in[e] = cur_rd_ff[32*e +: 32];
               acc_in[e] = '0;
            end
            j_in = '0;
            state_in = StFJChk;
         end
         StFJChk: begin
            cur_raddr = j_ff[IdxW-1:0];
            if (j_ff == n_ff) begin
               state_in = StFWrF;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = StFLatJ;
            end
         end
         StFLatJ: begin
            for (int e = 0; e < 3; e++) cj_in[e] = cur_rd_ff[32*e +: 32];
            r2_in = '0;
            k_in = '0;
            state_in = StPDiff;
         end
         StPDiff: begin
            wrap_in_in = 40'(ci_ff[k_ff]) - 40'(cj_ff[k_ff]);
            ret_in = StPSq;
            state_in = StWrapA;
         end
         StPSq: begin
            d_in[k_ff] = wres_ff;
            mul_a = wres_ff;
            mul_b = wres_ff;
            state_in = StPAcc;
         end
         StPAcc: begin
            r2_in = r2_ff + 64'(prod_ff);
            if (k_ff == 2'd2) begin
               k_in = '0;
               state_in = StPCmp;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = StPDiff;
            end
         end
         StPCmp: begin
            if (r2_ff >= cut2_ff) begin
               state_in = StPNextJ;
            end else if (r2_rnd[64:FracBits] == '0) begin
               s_in = 32'sh7FFF_FFFF;
               sat_set = 1'b1;
               state_in = StPS2;
            end else begin
               div_start = 1'b1;
               state_in = StPDiv;
            end
         end
         StPDiv: begin
            if (div_done) begin
               if (div_quo[DivNumW-1:31] != '0) begin
                  s_in = 32'sh7FFF_FFFF;
                  sat_set = 1'b1;
               end else begin
                  s_in = div_quo[31:0];
               end
               state_in = StPS2;
            end
         end
         StPS2: begin
            mul_a = s_ff;
            mul_b = s_ff;
            state_in = StPS2R;
         end
         StPS2R: begin
            s2_in = fr_sat;
            sat_set = fr_ovf;
            mul_a = fr_sat;
            mul_b = s_ff;
            state_in = StPS3R;
         end
         StPS3R: begin
            s3_in = fr_sat;
            sat_set = fr_ovf;
            mul_a = s2_ff;
            mul_b = s2_ff;
            state_in = StPS4R;
         end
         StPS4R: begin
            sat_set = fr_ovf || ovf32(t_val);
            mul_a = fr_sat;
            mul_b = t_sat;
            state_in = StPFacR;
         end
         StPFacR: begin
            factor_in = fr_sat;
            sat_set = fr_ovf;
            k_in = '0;
            state_in = StPDf;
         end
         StPDf: begin
            mul_a = d_ff[k_ff];
            mul_b = factor_ff;
            state_in = StPDfR;
         end
         StPDfR: begin
            acc_in[k_ff] = sat40(acc_sum);
            sat_set = fr_ovf || ovf40(acc_sum);
            if (k_ff == 2'd2) begin
               k_in = '0;
               state_in = StPNextJ;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = StPDf;
            end
         end
         StPNextJ: begin
            j_in = j_ff + 1'b1;
            state_in = StFJChk;
         end
         StFWrF: begin
            force_we = 1'b1;
            force_wdata = {acc_ff[2], acc_ff[1], acc_ff[0]};
            i_in = i_ff + 1'b1;
            if (i_in == n_ff) begin
               i_in = '0;
               state_in = StARd;
            end else begin
               state_in = StFRdI;
            end
         end
         StARd: state_in = StALat;
         StALat: begin
            for (int e = 0; e < 3; e++) begin
               ci_in[e] = cur_rd_ff[32*e +: 32];
               pi_in[e] = prev_rd_ff[32*e +: 32];
               fi_in[e] = force_rd_ff[AccW*e +: AccW];
            end
            k_in = '0;
            state_in = StAFd;
         end
         StAFd: begin
            mul_a = sat32(66'(fi_ff[k_ff]));
            sat_set = ovf32(66'(fi_ff[k_ff]));
            mul_b = {1'b0, stepsq_ff};
            state_in = StAFdR;
         end
         StAFdR: begin
            sat_set = fr_ovf;
            wrap_in_in = (40'(ci_ff[k_ff]) <<< 1) - 40'(pi_ff[k_ff]) + 40'(fr_sat);
            ret_in = StADisp;
            state_in = StWrapA;
         end
         StADisp: begin
            nxt_in[k_ff] = wres_ff;
            wrap_in_in = 40'(wres_ff) - 40'(pi_ff[k_ff]);
            ret_in = StAVel;
            state_in = StWrapA;
         end
         StAVel: begin
            mul_a = wres_ff;
            mul_b = {1'b0, halfinv_ff};
            state_in = StAVelR;
         end
         StAVelR: begin
            vel_in[k_ff] = fr_sat;
            sat_set = fr_ovf;
            if (k_ff == 2'd2) begin
               k_in = '0;
               state_in = StAWr;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = StAFd;
            end
         end
         StAWr: begin
            cur_we = 1'b1;
            prev_we = 1'b1;
            vel_we = 1'b1;
            cur_wdata = {nxt_ff[2], nxt_ff[1], nxt_ff[0]};
            prev_wdata = {ci_ff[2], ci_ff[1], ci_ff[0]};
            vel_wdata = {vel_ff[2], vel_ff[1], vel_ff[0]};
            vel_vld_in[i_ff[IdxW-1:0]] = 1'b1;
            i_in = i_ff + 1'b1;
            state_in = (i_in == n_ff) ? StDone : StARd;
         end
         StDone: begin
            for (int e = 0; e < 3; e++) begin
               rsp_pos_in[e] = '0;
               rsp_vel_in[e] = '0;
            end
            rsp_sat_in = flag_ff;
            rsp_valid_in = 1'b1;
            state_in = StIdle;
         end
         StWrapA: begin
            v_in = sat32(66'(wrap_in_ff));
            sat_set = ovf32(66'(wrap_in_ff));
            mul_a = v_in;
            mul_b = {1'b0, recip_ff};
            state_in = StWrapB;
         end
         StWrapB: begin
            mul_a = {{15{nr[64]}}, nr[64:2*FracBits]};
            mul_b = {1'b0, box_ff};
            state_in = StWrapC;
         end
         StWrapC: begin
            wres_in = sat32(wrap_diff);
            sat_set = ovf32(wrap_diff);
            state_in = ret_ff;
         end
         default: state_in = StIdle;
      endcase

      flag_in = flag_ff || sat_set;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         ret_ff       <= StIdle;
         count_ff     <= 9'd108;
         box_ff       <= 31'd77846282;
         recip_ff     <= 31'd3619672;
         cutoff_ff    <= 31'd41943040;
         stepsq_ff    <= 31'd168;
         halfinv_ff   <= 31'd838860800;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vel_vld_ff   <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         count_ff     <= count_in;
         box_ff       <= box_in;
         recip_ff     <= recip_in;
         cutoff_ff    <= cutoff_in;
         stepsq_ff    <= stepsq_in;
         halfinv_ff   <= halfinv_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
         vel_vld_ff   <= vel_vld_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
      end
      rsp_sat_ff <= rsp_sat_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_vel_ff <= rsp_vel_in;
      ci_ff      <= ci_in;
      cj_ff      <= cj_in;
      pi_ff      <= pi_in;
      fi_ff      <= fi_in;
      d_ff       <= d_in;
      nxt_ff     <= nxt_in;
      vel_ff     <= vel_in;
      acc_ff     <= acc_in;
      r2_ff      <= r2_in;
      cut2_ff    <= cut2_in;
      s_ff       <= s_in;
      s2_ff      <= s2_in;
      s3_ff      <= s3_in;
      factor_ff  <= factor_in;
      v_ff       <= v_in;
      wres_ff    <= wres_in;
      wrap_in_ff <= wrap_in_in;
      prod_ff    <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[waddr] <= cur_wdata;
      end
      cur_rd_ff <= cur_mem[cur_raddr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[waddr] <= prev_wdata;
      end
      prev_rd_ff <= prev_mem[i_ff[IdxW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (force_we) begin
         force_mem[waddr] <= force_wdata;
      end
      force_rd_ff <= force_mem[i_ff[IdxW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (vel_we) begin
         vel_mem[waddr] <= vel_wdata;
      end
      vel_rd_ff     <= vel_mem[req_particle_index];
      vel_vld_rd_ff <= vel_vld_ff[req_particle_index];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pos_x     = rsp_pos_ff[0];
   assign rsp_pos_y     = rsp_pos_ff[1];
   assign rsp_pos_z     = rsp_pos_ff[2];
   assign rsp_vel_x     = rsp_vel_ff[0];
   assign rsp_vel_y     = rsp_vel_ff[1];
   assign rsp_vel_z     = rsp_vel_ff[2];
   assign rsp_saturated = rsp_sat_ff;

endmodule
`default_nettype wire

// File: tb/lj_force_verlet_step_tb.sv
`default_nettype none
module lj_force_verlet_step_tb;
   import ljv_pkg::*;

   localparam logic [1:0] FuncNone = 2'd3;
   localparam longint AccMax = 64'sd549755813887;
   localparam longint AccMin = -64'sd549755813888;

   typedef struct {
      int val[6];
      bit sat;
   } md_result_type;

   class md_scoreboard;
      longint n_count, box, recip, cutoff, stepsq, halfinv;
      int cur[MaxParticles][3];
      int prv[MaxParticles][3];
      int vel[MaxParticles][3];
      longint frc[MaxParticles][3];
      bit sat_flag;
      md_result_type pending[$];
      int errors;
      string field_name[6] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};

      function new();
         n_count = 108;
         box = 77846282;
         recip = 3619672;
         cutoff = 41943040;
         stepsq = 168;
         halfinv = 838860800;
         foreach (vel[i, k]) begin
            vel[i][k] = 0;
            cur[i][k] = 0;
            prv[i][k] = 0;
            frc[i][k] = 0;
         end
         sat_flag = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            CsrCount:   n_count = data & 32'h1FF;
            CsrBox:     box = data & 32'h7FFF_FFFF;
            CsrRecip:   recip = data & 32'h7FFF_FFFF;
            CsrCutoff:  cutoff = data & 32'h7FFF_FFFF;
            CsrStepSq:  stepsq = data & 32'h7FFF_FFFF;
            CsrHalfInv: halfinv = data & 32'h7FFF_FFFF;
            default: ;
         endcase
      endfunction

      function int clamp32(longint v);
         if (v > 64'sd2147483647) begin
            sat_flag = 1;
            return 32'h7FFF_FFFF;
         end
         if (v < -64'sd2147483648) begin
            sat_flag = 1;
            return 32'h8000_0000;
         end
         return int'(v);
      endfunction

      function int qmul(int a, int b);
         longint p;
         p = longint'(a) * longint'(b);
         return clamp32((p + (64'sd1 <<< (FracBits - 1))) >>> FracBits);
      endfunction

      function int box_wrap(longint r);
         longint v, p, n;
         v = clamp32(r);
         p = v * recip;
         n = (p + (64'sd1 <<< (2 * FracBits - 1))) >>> (2 * FracBits);
         return clamp32(v - n * box);
      endfunction

      function void add_pair(int a, int b);
         int d[3];
         longint unsigned r2, r2q, q, cut2;
         int s, s2, s3, s4, t, factor;
         longint acc;
         r2 = 0;
         for (int k = 0; k < 3; k++) begin
            d[k] = box_wrap(longint'(cur[a][k]) - longint'(cur[b][k]));
            r2 += longint'(unsigned'(0)) + longint'(d[k]) * longint'(d[k]);
         end
         cut2 = longint'(cutoff) * longint'(cutoff);
         if (!(r2 < cut2)) return;
         r2q = (r2 + (64'd1 << (FracBits - 1))) >> FracBits;
         if (r2q == 0) begin
            sat_flag = 1;
            s = 32'h7FFF_FFFF;
         end else begin
            q = ((64'd1 << (2 * FracBits)) + (r2q >> 1)) / r2q;
            if (q > 64'd2147483647) begin
               sat_flag = 1;
               s = 32'h7FFF_FFFF;
            end else begin
               s = int'(q);
            end
         end
         s2 = qmul(s, s);
         s3 = qmul(s2, s);
         s4 = qmul(s2, s2);
         t = clamp32(48 * longint'(s3) - 24 * (64'sd1 <<< FracBits));
         factor = qmul(s4, t);
         for (int k = 0; k < 3; k++) begin
            acc = frc[a][k] + longint'(qmul(d[k], factor));
            if (acc > AccMax) begin
               sat_flag = 1;
               acc = AccMax;
            end
            if (acc < AccMin) begin
               sat_flag = 1;
               acc = AccMin;
            end
            frc[a][k] = acc;
         end
      endfunction

      function void advance_all();
         int n, f, fd, nxt, disp;
         longint sum;
         n = (n_count > MaxParticles) ? MaxParticles : int'(n_count);
         for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 3; k++) frc[i][k] = 0;
            for (int j = 0; j < n; j++) if (j != i) add_pair(i, j);
         end
         for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 3; k++) begin
               f = clamp32(frc[i][k]);
               fd = qmul(f, int'(stepsq));
               sum = 2 * longint'(cur[i][k]) - longint'(prv[i][k]) + longint'(fd);
               nxt = box_wrap(sum);
               disp = box_wrap(longint'(nxt) - longint'(prv[i][k]));
               vel[i][k] = qmul(disp, int'(halfinv));
               prv[i][k] = cur[i][k];
               cur[i][k] = nxt;
            end
         end
      endfunction

      function void note_request(logic [1:0] func, int idx, int ld[6]);
         md_result_type r;
         foreach (r.val[k]) r.val[k] = 0;
         case (func)
            FuncLoad: begin
               for (int k = 0; k < 3; k++) begin
                  cur[idx][k] = ld[k];
                  prv[idx][k] = ld[3 + k];
               end
            end
            FuncStep: advance_all();
            FuncRead: begin
               for (int k = 0; k < 3; k++) begin
                  r.val[k] = cur[idx][k];
                  r.val[3 + k] = vel[idx][k];
               end
            end
            default: ;
         endcase
         r.sat = sat_flag;
         pending.push_back(r);
      endfunction

      function void check_response(logic signed [31:0] got[6], logic got_sat);
         md_result_type e;
         if (pending.size() == 0) begin
            $error("response with no transaction outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         for (int k = 0; k < 6; k++) begin
            if (got[k] !== e.val[k]) begin
               $error("%s: expected %0d, got %0d", field_name[k], e.val[k], got[k]);
               errors++;
            end
         end
         if (got_sat !== e.sat) begin
            $error("saturated: expected %0d, got %0d", e.sat, got_sat);
            errors++;
         end
      endfunction
   endclass

   typedef struct {
      int count;
      int unsigned box, recip, cutoff, stepsq, halfinv;
      int send_idle, recv_stall, step_pct, items;
   } phase_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [1:0] req_func;
   logic [7:0] req_particle_index;
   logic signed [31:0] req_load_x, req_load_y, req_load_z;
   logic signed [31:0] req_load_prev_x, req_load_prev_y, req_load_prev_z;
   logic rsp_valid, rsp_ready;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [31:0] rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic rsp_saturated;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [31:0] csr_wdata;

   md_scoreboard sb;
   int send_idle, recv_stall;
   int unsigned cur_box;
   bit loaded[MaxParticles];
   int written[$];
   int n_loads, n_reads, n_steps, n_other;

   lj_force_verlet_step DUT (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(0, 99) < recv_stall) ? 1'b0 : 1'b1;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_response('{rsp_pos_x, rsp_pos_y, rsp_pos_z,
                                rsp_vel_x, rsp_vel_y, rsp_vel_z}, rsp_saturated);
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic drive_item(logic [1:0] func, int idx, int ld[6]);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_func = func;
      req_particle_index = 8'(idx);
      {req_load_x, req_load_y, req_load_z} = {ld[0], ld[1], ld[2]};
      {req_load_prev_x, req_load_prev_y, req_load_prev_z} = {ld[3], ld[4], ld[5]};
      do @(posedge clock); while (!req_ready);
      sb.note_request(func, idx, ld);
      case (func)
         FuncLoad: begin
            n_loads++;
            if (!loaded[idx]) written.push_back(idx);
            loaded[idx] = 1;
         end
         FuncStep: n_steps++;
         FuncRead: n_reads++;
         default:  n_other++;
      endcase
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic int coord();
      if (cur_box == 0) return $urandom_range(0, 1 << 27);
      return $urandom_range(0, cur_box - 1);
   endfunction

   task automatic load_random(int idx, bit noise);
      int ld[6];
      for (int k = 0; k < 3; k++) begin
         if (noise) begin
            ld[k] = $urandom;
            ld[3 + k] = $urandom;
         end else begin
            ld[k] = coord();
            ld[3 + k] = ld[k] + $urandom_range(0, 1 << 17) - (1 << 16);
         end
      end
      drive_item(FuncLoad, idx, ld);
   endtask

   task automatic read_random();
      int ld[6];
      foreach (ld[k]) ld[k] = $urandom;
      drive_item(FuncRead, written[$urandom_range(0, written.size() - 1)], ld);
   endtask

   task automatic step_all(int n);
      int ld[6];
      for (int j = 0; j < n; j++) if (!loaded[j]) load_random(j, 0);
      foreach (ld[k]) ld[k] = $urandom;
      drive_item(FuncStep, $urandom_range(0, 255), ld);
   endtask

   task automatic set_phase(phase_type p);
      write_reg(CsrCount, p.count);
      write_reg(CsrBox, p.box);
      write_reg(CsrRecip, p.recip);
      write_reg(CsrCutoff, p.cutoff);
      write_reg(CsrStepSq, p.stepsq);
      write_reg(CsrHalfInv, p.halfinv);
      cur_box = p.box;
      send_idle = p.send_idle;
      recv_stall = p.recv_stall;
   endtask

   task automatic run_phase(phase_type p);
      int n, r, ld[6];
      n = (p.count > MaxParticles) ? MaxParticles : p.count;
      for (int i = 0; i < p.items; i++) begin
         r = $urandom_range(0, 99);
         if (r < p.step_pct) begin
            step_all(n);
         end else if (r < p.step_pct + 3) begin
            foreach (ld[k]) ld[k] = $urandom;
            drive_item(FuncNone, $urandom_range(0, 255), ld);
         end else if (r < 55 || written.size() == 0) begin
            if ($urandom_range(0, 3) == 0 || n < 2)
               load_random($urandom_range(0, 255), $urandom_range(0, 6) == 0);
            else
               load_random($urandom_range(0, n - 1), $urandom_range(0, 6) == 0);
         end else begin
            read_random();
         end
      end
   endtask

   phase_type phases[$];
   int ld[6];

   initial begin
      reset = 1;
      req_valid = 0;
      req_func = FuncLoad;
      req_particle_index = 0;
      {req_load_x, req_load_y, req_load_z} = '0;
      {req_load_prev_x, req_load_prev_y, req_load_prev_z} = '0;
      csr_valid = 0;
      csr_index = CsrCount;
      csr_wdata = 0;
      send_idle = 0;
      recv_stall = 0;
      cur_box = 77846282;
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      phases.push_back('{4, 77846282, 3619672, 41943040, 168, 838860800, 0, 0, 7, 260});
      phases.push_back('{6, 77846282, 3619672, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
                         59, 0, 7, 230});
      phases.push_back('{3, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 59, 7, 220});
      phases.push_back('{2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 41943040, 168, 838860800,
                         59, 59, 7, 200});
      phases.push_back('{1, 77846282, 3619672, 41943040, 168, 838860800, 0, 0, 7, 150});
      phases.push_back('{0, 50331648, 5592405, 25165824, 4096, 83886080, 18, 18, 5, 150});
      phases.push_back('{16, 77846282, 3619672, 41943040, 168, 838860800, 0, 0, 2, 220});
      phases.push_back('{256, 77846282, 3619672, 41943040, 168, 838860800, 18, 18, 0, 180});
      phases.push_back('{511, 77846282, 3619672, 41943040, 168, 838860800, 0, 0, 0, 170});

      set_phase(phases[0]);

      ld = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      drive_item(FuncLoad, 0, ld);
      ld = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      drive_item(FuncLoad, 1, ld);
      ld = '{16777216, 16777216, 16777216, 16777000, 16777216, 16777300};
      drive_item(FuncLoad, 2, ld);
      drive_item(FuncLoad, 3, ld);
      ld = '{-1, 0, 32'h5555_5555, 32'hAAAA_AAAA, 1, -2};
      drive_item(FuncLoad, 255, ld);
      drive_item(FuncRead, 0, ld);
      drive_item(FuncRead, 1, ld);
      drive_item(FuncRead, 255, ld);
      drive_item(FuncNone, 255, ld);
      drive_item(FuncStep, 0, ld);
      for (int j = 0; j < 4; j++) drive_item(FuncRead, j, ld);
      load_random(0, 0);
      load_random(1, 0);
      drive_item(FuncStep, 255, ld);
      drive_item(FuncRead, 0, ld);
      drive_item(FuncRead, 2, ld);
      drive_item(FuncNone, 0, ld);
      drain();

      foreach (phases[p]) begin
         if (p != 0) set_phase(phases[p]);
         run_phase(phases[p]);
         drain();
      end

      $display("Covered %0d loads, %0d reads, %0d steps and %0d unknown requests",
               n_loads, n_reads, n_steps, n_other);
      $display("across %0d register settings with varied sender and receiver idling",
               phases.size());
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: files.f
rtl/ljv_pkg.sv
rtl/ljv_div.sv
rtl/lj_force_verlet_step.sv
tb/lj_force_verlet_step_tb.sv
